### src/peakoc_pkg.sv
// Shared types and constants for the peak occurrence check block.
// Used by the controller, the datapath and the top level.
package peakoc_pkg;

   localparam int DEPTH_DEF       = 1024;
   localparam int HALF_WINDOW_DEF = 16;

   localparam int IDX_W      = 10;
   localparam int COEF_W     = 32;
   localparam int LEN_W      = 11;
   localparam int THR_S_W    = 31;
   localparam int CONF_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int QUOT_W     = 10;
   localparam int NUM_W      = 42;
   localparam int CONF_SCALE = 1000;

   localparam int REQ_DATA_W = 80;   // 74 payload bits padded to whole bytes
   localparam int RSP_DATA_W = 24;   // 20 payload bits padded to whole bytes

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } req_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_USED_LENGTH   = 2'd0,
      REG_THR_PRIMARY   = 2'd1,
      REG_THR_SECONDARY = 2'd2,
      REG_MIN_CONF      = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_P,
      ST_FLUSH_P,
      ST_WIN,
      ST_SCAN_S,
      ST_FLUSH_S,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_p;
      logic win;
      logic scan_s;
      logic check;
      logic mul;
      logic div;
      logic wr;
      logic result;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_none;
      logic cnt_last;
      logic win_empty;
      logic corr_low;
      logic div_last;
      logic rsp_free;
   } dp_status_type;

endpackage

### src/peakoc_ctrl.sv
// Sequencing state machine for the peak occurrence check.
// Depends on peakoc_pkg; drives the datapath through dp_cmd_type.
module peakoc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tuser,
   output logic                     req_tready,
   output peakoc_pkg::dp_cmd_type   cmd,
   input  peakoc_pkg::dp_status_type status
);
   import peakoc_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd_type'(req_tuser) == CMD_QUERY) begin
                  cmd.start = 1'b1;
                  state_in  = status.scan_none ? ST_WIN : ST_SCAN_P;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN_P: begin
            cmd.scan_p = 1'b1;
            if (status.cnt_last) state_in = ST_FLUSH_P;
         end
         ST_FLUSH_P: state_in = ST_WIN;
         ST_WIN: begin
            cmd.win  = 1'b1;
            state_in = status.win_empty ? ST_RESULT : ST_SCAN_S;
         end
         ST_SCAN_S: begin
            cmd.scan_s = 1'b1;
            if (status.cnt_last) state_in = ST_FLUSH_S;
         end
         ST_FLUSH_S: state_in = ST_CHECK;
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.corr_low ? ST_RESULT : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.div_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.wr = 1'b1;
            if (status.cnt_last) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/peakoc_dp.sv
// Datapath: coefficient row memories, scan compare, divider and result register.
// Depends on peakoc_pkg; driven by peakoc_ctrl commands.
module peakoc_dp #(
   parameter int DEPTH       = peakoc_pkg::DEPTH_DEF,
   parameter int HALF_WINDOW = peakoc_pkg::HALF_WINDOW_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  peakoc_pkg::dp_cmd_type                cmd,
   output peakoc_pkg::dp_status_type             status,
   input  logic                                  csr_valid,
   input  logic [peakoc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [peakoc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [peakoc_pkg::IDX_W-1:0]          req_index,
   input  logic signed [peakoc_pkg::COEF_W-1:0]  req_primary,
   input  logic signed [peakoc_pkg::COEF_W-1:0]  req_secondary,
   input  logic                                  rsp_tready,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [peakoc_pkg::IDX_W-1:0]          rsp_peak,
   output logic [peakoc_pkg::CONF_W-1:0]         rsp_conf
);
   import peakoc_pkg::*;

   localparam int AW     = $clog2(DEPTH);
   localparam int LW_RAW = $clog2(DEPTH + 1);
   localparam int XW     = ((LW_RAW > LEN_W) ? LW_RAW : LEN_W) + 2;

   // configuration
   logic [LEN_W-1:0]          used_len_ff;
   logic signed [COEF_W-1:0]  thr_p_ff;
   logic [THR_S_W-1:0]        thr_s_ff;
   logic [CONF_W-1:0]         min_conf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_len_ff <= '0;
         thr_p_ff    <= '0;
         thr_s_ff    <= '0;
         min_conf_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_USED_LENGTH:   used_len_ff <= csr_data[LEN_W-1:0];
            REG_THR_PRIMARY:   thr_p_ff    <= csr_data;
            REG_THR_SECONDARY: thr_s_ff    <= csr_data[THR_S_W-1:0];
            REG_MIN_CONF:      min_conf_ff <= csr_data[CONF_W-1:0];
            default: ;
         endcase
      end
   end

   // row memories
   logic [COEF_W-1:0] mem_p [DEPTH];
   logic [COEF_W-1:0] mem_s [DEPTH];
   logic [COEF_W-1:0] p_q_ff, s_q_ff;

   logic [XW-1:0] len_ff, cnt_ff, ptr_ff, k_ff, a_ff, span_ff, rd_idx_ff;
   logic          first_ff, rdp_vld_ff, rds_vld_ff, reject_ff;

   logic [XW-1:0] p_x, len_w, cnt_w;
   logic          load_ok, we;
   logic [AW-1:0] waddr;
   logic [COEF_W-1:0] wdata_p, wdata_s;

   assign p_x     = XW'(req_index);
   assign len_w   = (XW'(used_len_ff) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(used_len_ff);
   assign load_ok = p_x < XW'(DEPTH);

   always_comb begin
      cnt_w = '0;
      if (p_x + XW'(1) < len_w) begin
         cnt_w = len_w - XW'(1) - p_x;
         if (cnt_w > XW'(HALF_WINDOW + 1)) cnt_w = XW'(HALF_WINDOW + 1);
      end
   end

   assign we      = (cmd.load && load_ok) || cmd.wr;
   assign waddr   = cmd.load ? AW'(req_index) : ptr_ff[AW-1:0];
   assign wdata_p = cmd.load ? req_primary : thr_p_ff;
   assign wdata_s = cmd.load ? req_secondary : {1'b0, thr_s_ff};

   always_ff @(posedge clock) begin
      if (we) begin
         mem_p[waddr] <= wdata_p;
         mem_s[waddr] <= wdata_s;
      end
      if (cmd.scan_p) p_q_ff <= mem_p[ptr_ff[AW-1:0]];
      if (cmd.scan_s) s_q_ff <= mem_s[ptr_ff[AW-1:0]];
   end

   // window bounds
   logic [XW-1:0] a_w, b_w, kw;
   logic          empty_w;
   assign kw      = k_ff + XW'(HALF_WINDOW);
   assign a_w     = (k_ff >= XW'(HALF_WINDOW)) ? k_ff - XW'(HALF_WINDOW) : '0;
   assign b_w     = (kw > len_ff - XW'(1)) ? len_ff - XW'(1) : kw;
   assign empty_w = (len_ff == '0) || (b_w <= a_w);

   // row two extremes, saturating magnitude
   logic signed [COEF_W-1:0] best_ff, mx_ff, mn_ff;
   logic [THR_S_W-1:0]       m1_w, m2_w, mbig_ff;

   function automatic logic [THR_S_W-1:0] sat_abs(input logic signed [COEF_W-1:0] x);
      logic [COEF_W-1:0] n;
      n = COEF_W'(-x);
      if (x[COEF_W-1]) begin
         sat_abs = (x == {1'b1, {(COEF_W-1){1'b0}}}) ? {THR_S_W{1'b1}} : n[THR_S_W-1:0];
      end else begin
         sat_abs = x[THR_S_W-1:0];
      end
   endfunction

   assign m1_w = sat_abs(mx_ff);
   assign m2_w = sat_abs(mn_ff);

   // restoring divider, one quotient bit per cycle
   logic [NUM_W-1:0]  rem_ff, dsr_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [3:0]        div_cnt_ff;
   logic [CONF_W-1:0] conf_w;
   assign conf_w = CONF_W'(CONF_SCALE) - q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rdp_vld_ff <= 1'b0;
         rds_vld_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         rdp_vld_ff <= cmd.scan_p;
         rds_vld_ff <= cmd.scan_s;
         if (cmd.result) rsp_valid <= 1'b1;
         else if (rsp_tready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= ptr_ff;
      if (cmd.start) begin
         len_ff    <= len_w;
         cnt_ff    <= cnt_w;
         ptr_ff    <= p_x;
         k_ff      <= p_x;
         first_ff  <= 1'b1;
         reject_ff <= 1'b0;
      end
      if (cmd.scan_p || cmd.scan_s || cmd.wr) begin
         ptr_ff <= ptr_ff + XW'(1);
         cnt_ff <= cnt_ff - XW'(1);
      end
      if (rdp_vld_ff) begin
         first_ff <= 1'b0;
         if (first_ff || ($signed(p_q_ff) > best_ff)) begin
            best_ff <= p_q_ff;
            k_ff    <= rd_idx_ff;
         end
      end
      if (cmd.win) begin
         ptr_ff    <= a_w;
         a_ff      <= a_w;
         cnt_ff    <= b_w - a_w;
         span_ff   <= b_w - a_w;
         reject_ff <= empty_w;
         first_ff  <= 1'b1;
      end
      if (rds_vld_ff) begin
         first_ff <= 1'b0;
         if (first_ff || ($signed(s_q_ff) > mx_ff)) mx_ff <= s_q_ff;
         if (first_ff || ($signed(s_q_ff) < mn_ff)) mn_ff <= s_q_ff;
      end
      if (cmd.check) begin
         mbig_ff   <= (m1_w > m2_w) ? m1_w : m2_w;
         reject_ff <= status.corr_low;
      end
      if (cmd.mul) begin
         rem_ff     <= NUM_W'(thr_s_ff) * NUM_W'(CONF_SCALE);
         dsr_ff     <= NUM_W'(mbig_ff) << (QUOT_W - 1);
         div_cnt_ff <= 4'(QUOT_W - 1);
         q_ff       <= '0;
         ptr_ff     <= a_ff;
         cnt_ff     <= span_ff;
      end
      if (cmd.div) begin
         if (rem_ff >= dsr_ff) begin
            rem_ff <= rem_ff - dsr_ff;
            q_ff   <= {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[QUOT_W-2:0], 1'b0};
         end
         dsr_ff     <= dsr_ff >> 1;
         div_cnt_ff <= div_cnt_ff - 4'd1;
      end
      if (cmd.result) begin
         rsp_peak  <= k_ff[IDX_W-1:0];
         rsp_found <= !reject_ff && (conf_w >= min_conf_ff);
         rsp_conf  <= reject_ff ? '0 : conf_w;
      end
   end

   always_comb begin
      status.scan_none = (cnt_w == '0);
      status.cnt_last  = (cnt_ff == XW'(1));
      status.win_empty = empty_w;
      status.corr_low  = (((m1_w < m2_w) ? m1_w : m2_w) <= thr_s_ff);
      status.div_last  = (div_cnt_ff == '0);
      status.rsp_free  = !rsp_valid || rsp_tready;
   end

endmodule

### src/peak_occurrence_check_core.sv
// Top level of the peak occurrence check: controller plus datapath.
// Depends on peakoc_pkg, peakoc_ctrl and peakoc_dp.
//
//   channel  direction  contents
//   req_*    in         tuser: command; tdata: index, primary, secondary
//   rsp_*    out        tuser: found; tdata: peak_index, confidence
//   csr_*    in         index and data of a register write
//
// A load is written while the controller stays idle. A query scans n rows for
// the peak (n up to HALF_WINDOW+1), then reads and rewrites s window rows (s up to
// 2*HALF_WINDOW): one row memory read or write per cycle plus a restoring
// divider at one quotient bit a cycle. Reset does not clear the row memories. A
// query waits before its result while the previous result is not taken.
module peak_occurrence_check_core #(
   parameter int DEPTH       = peakoc_pkg::DEPTH_DEF,
   parameter int HALF_WINDOW = peakoc_pkg::HALF_WINDOW_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic                                   req_tuser,  // command
   // index, primary_value, secondary_value
   input  logic [peakoc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tuser,  // found
   // peak_index, confidence
   output logic [peakoc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [peakoc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [peakoc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import peakoc_pkg::*;

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [IDX_W-1:0]  peak;
   logic [CONF_W-1:0] conf;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {{(RSP_DATA_W - IDX_W - CONF_W){1'b0}}, conf, peak};

   peakoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   peakoc_dp #(
      .DEPTH       (DEPTH),
      .HALF_WINDOW (HALF_WINDOW)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_index     (req_tdata[IDX_W-1:0]),
      .req_primary   (req_tdata[IDX_W+COEF_W-1:IDX_W]),
      .req_secondary (req_tdata[IDX_W+2*COEF_W-1:IDX_W+COEF_W]),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_found     (rsp_tuser),
      .rsp_peak      (peak),
      .rsp_conf      (conf)
   );

endmodule

### src/peakoc_checker.sv
// Port-level checks for peak_occurrence_check_core, attached by bind.
// Depends on peakoc_pkg for widths and codes.
module peakoc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic                                rsp_tuser,
   input logic [peakoc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import peakoc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // a load leaves the input side ready
   a_load_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_LOAD) |=> req_tready)
      else $error("load held the input side");

   // a query blocks further input while it runs
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_QUERY) |=> !req_tready)
      else $error("input taken during a query");

   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[IDX_W+CONF_W-1:IDX_W] <= CONF_W'(CONF_SCALE))
      else $error("confidence out of range");

   a_found_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[IDX_W+CONF_W-1:IDX_W] != '0)
      else $error("occurrence reported with zero confidence");

endmodule

bind peak_occurrence_check_core peakoc_checker u_peakoc_checker (.*);
